>>> sv/rgbhsl_pkg.sv
// Types, constants and the restoring-division step for the RGB to HSL converter.
// No dependencies; imported by the converter, its checker and the testbench.
`default_nettype none

package rgbhsl_pkg;

  localparam int unsigned QuotW        = 7;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned DivStages    = (QuotW + BitsPerStage - 1) / BitsPerStage;
  localparam int unsigned Latency      = DivStages + 3;

  localparam logic [8:0]  FullTurn    = 9'd360;
  localparam logic [8:0]  GreenBase   = 9'd120;
  localparam logic [8:0]  BlueBase    = 9'd240;
  localparam logic [8:0]  SpanSum     = 9'd510;
  // half the sum at most 128 means the sum itself is at most 257
  localparam logic [8:0]  SatSplitSum = 9'd257;
  localparam logic [15:0] HueScale    = 16'd60;
  localparam logic [15:0] PctScale    = 16'd100;
  // 50 * 32897: exact floor of 100 * sum / 510 after a right shift by 23
  localparam logic [29:0] LightMul    = 30'd1644850;
  localparam int unsigned LightShift  = 23;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [15:0]      rem;
    logic [QuotW-1:0] quot;
  } div_t;

  typedef struct packed {
    div_t       hue;
    logic [8:0] hue_den;
    div_t       sat;
    logic [8:0] sat_den;
    sector_e    sector;
    logic       neg;
    logic       grey;
    logic [6:0] light;
  } div_pipe_t;

  function automatic div_t div_step(div_t cur, logic [8:0] den, int unsigned k);
    logic [15:0] trial;
    div_t        nxt;
    trial    = {7'd0, den} << k;
    nxt.quot = {cur.quot[QuotW-2:0], 1'b0};
    if (cur.rem >= trial) begin
      nxt.rem     = cur.rem - trial;
      nxt.quot[0] = 1'b1;
    end else begin
      nxt.rem = cur.rem;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

>>> sv/rgb_to_hsl_converter.sv
// RGB to HSL converter top level: pipelined max/min, scaling and two restoring dividers.
// Depends on rgbhsl_pkg.
`default_nettype none

// Takes one packed RGB pixel per clock and returns hue in whole degrees, saturation
// and lightness in whole percent, all truncated; grey pixels give hue and saturation 0.
// Every request taken with start_i high and busy_o low yields exactly one result,
// shown for one cycle with done_o high, in request order.
// The latency is set by the two shared-shape restoring dividers, which resolve up to two
// quotient bits per stage over four stages. busy_o is high only while reset is held;
// results cannot be held off, and none is needed as nothing ever stalls.
module rgb_to_hsl_converter
  import rgbhsl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [23:0] pixel_rgb_i,
  output      logic        done_o,
  output      logic [8:0]  hue_deg_o,
  output      logic [6:0]  sat_pct_o,
  output      logic [6:0]  light_pct_o
);

  logic [7:0] red, green, blue;
  logic [7:0] mx, mn;
  logic [7:0] diff_d;
  logic       neg_d;
  sector_e    sector_d;

  logic       v1_q;
  sector_e    sector_q;
  logic [7:0] spread_q;
  logic [8:0] sum_q;
  logic [7:0] diff_q;
  logic       neg_q;

  div_pipe_t  pipe_d [DivStages+1];
  div_pipe_t  pipe_q [DivStages+1];
  logic       pipe_v_q [DivStages+1];

  logic       done_q;
  logic [8:0] hue_d, hue_q;
  logic [6:0] sat_d, sat_q;
  logic [6:0] light_q;

  logic [29:0] light_prod;
  logic        rem_nz;
  logic [8:0]  quot9;

  assign busy_o = ~rst_ni;

  // stage 1: largest and smallest channel, sector and signed channel difference
  assign red   = pixel_rgb_i[23:16];
  assign green = pixel_rgb_i[15:8];
  assign blue  = pixel_rgb_i[7:0];

  always_comb begin
    priority if (blue >= red && blue >= green) begin
      sector_d = SecBlue;
      mx       = blue;
    end else if (green >= red && green >= blue) begin
      sector_d = SecGreen;
      mx       = green;
    end else begin
      sector_d = SecRed;
      mx       = red;
    end
    priority if (blue <= red && blue <= green) begin
      mn = blue;
    end else if (green <= red && green <= blue) begin
      mn = green;
    end else begin
      mn = red;
    end
    unique case (sector_d)
      SecRed: begin
        neg_d  = green < blue;
        diff_d = neg_d ? blue - green : green - blue;
      end
      SecGreen: begin
        neg_d  = blue < red;
        diff_d = neg_d ? red - blue : blue - red;
      end
      SecBlue: begin
        neg_d  = red < green;
        diff_d = neg_d ? green - red : red - green;
      end
      default: begin
        neg_d  = 1'b0;
        diff_d = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    spread_q <= mx - mn;
    sum_q    <= {1'b0, mx} + {1'b0, mn};
    diff_q   <= diff_d;
    neg_q    <= neg_d;
  end

  // stage 2: dividends, divisors and lightness
  assign light_prod = 30'(sum_q) * LightMul;

  always_comb begin
    pipe_d[0].hue.rem   = 16'(diff_q) * HueScale;
    pipe_d[0].hue.quot  = '0;
    pipe_d[0].hue_den   = {1'b0, spread_q};
    pipe_d[0].sat.rem   = 16'(spread_q) * PctScale;
    pipe_d[0].sat.quot  = '0;
    pipe_d[0].sat_den   = (sum_q <= SatSplitSum) ? sum_q : SpanSum - sum_q;
    pipe_d[0].sector    = sector_q;
    pipe_d[0].neg       = neg_q;
    pipe_d[0].grey      = spread_q == 8'd0;
    pipe_d[0].light     = 7'(light_prod >> LightShift);
  end

  // divider stages, most significant quotient bits first
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    always_comb begin
      pipe_d[s+1] = pipe_q[s];
      for (int j = 0; j < BitsPerStage; j++) begin
        if (int'(QuotW) - 1 - int'(BitsPerStage) * s - j >= 0) begin
          pipe_d[s+1].hue = div_step(pipe_d[s+1].hue, pipe_q[s].hue_den,
                                     QuotW - 1 - BitsPerStage * s - j);
          pipe_d[s+1].sat = div_step(pipe_d[s+1].sat, pipe_q[s].sat_den,
                                     QuotW - 1 - BitsPerStage * s - j);
        end
      end
    end
  end

  for (genvar s = 0; s <= DivStages; s++) begin : g_pipe
    always_ff @(posedge clk_i) begin
      pipe_q[s] <= pipe_d[s];
    end
  end

  // final stage: sector offset, wrap and grey override
  assign rem_nz = pipe_q[DivStages].hue.rem != 16'd0;
  assign quot9  = 9'(pipe_q[DivStages].hue.quot);

  always_comb begin
    unique case (pipe_q[DivStages].sector)
      SecRed: begin
        if (pipe_q[DivStages].neg && quot9 != 9'd0) begin
          hue_d = FullTurn - quot9;
        end else begin
          hue_d = quot9;
        end
      end
      SecGreen: begin
        hue_d = pipe_q[DivStages].neg ? GreenBase - quot9 - 9'(rem_nz)
                                      : GreenBase + quot9;
      end
      SecBlue: begin
        hue_d = pipe_q[DivStages].neg ? BlueBase - quot9 - 9'(rem_nz)
                                      : BlueBase + quot9;
      end
      default: hue_d = 9'd0;
    endcase
    sat_d = pipe_q[DivStages].sat.quot;
    if (pipe_q[DivStages].grey) begin
      hue_d = 9'd0;
      sat_d = 7'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q   <= hue_d;
    sat_q   <= sat_d;
    light_q <= pipe_q[DivStages].light;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
      for (int s = 0; s <= DivStages; s++) begin
        pipe_v_q[s] <= 1'b0;
      end
    end else begin
      v1_q        <= start_i & ~busy_o;
      pipe_v_q[0] <= v1_q;
      for (int s = 1; s <= DivStages; s++) begin
        pipe_v_q[s] <= pipe_v_q[s-1];
      end
      done_q <= pipe_v_q[DivStages];
    end
  end

  assign done_o      = done_q;
  assign hue_deg_o   = hue_q;
  assign sat_pct_o   = sat_q;
  assign light_pct_o = light_q;

endmodule

`default_nettype wire

>>> sv/rgbhsl_checker.sv
// Port-level checker for the RGB to HSL converter, bound to the top level.
// Depends on rgbhsl_pkg for the pipeline latency.
`default_nettype none

module rgbhsl_checker
  import rgbhsl_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic [23:0] pixel_rgb_i,
  input wire logic        done_o,
  input wire logic [8:0]  hue_deg_o,
  input wire logic [6:0]  sat_pct_o,
  input wire logic [6:0]  light_pct_o
);

  // one result per request, at a fixed latency
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start_i && !busy_o, Latency))
    else $error("result strobe does not match request %0d cycles earlier", Latency);

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> hue_deg_o < 9'd360)
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sat_pct_o <= 7'd100 && light_pct_o <= 7'd100))
    else $error("percentage out of range");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o
     && $past(pixel_rgb_i[23:16], Latency) == $past(pixel_rgb_i[15:8], Latency)
     && $past(pixel_rgb_i[15:8], Latency) == $past(pixel_rgb_i[7:0], Latency))
    |-> (hue_deg_o == 9'd0 && sat_pct_o == 7'd0))
    else $error("grey pixel gave non-zero hue or saturation");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .pixel_rgb_i (pixel_rgb_i),
  .done_o      (done_o),
  .hue_deg_o   (hue_deg_o),
  .sat_pct_o   (sat_pct_o),
  .light_pct_o (light_pct_o)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for rgb_to_hsl_converter: directed and random pixels,
// each request checked against an in-bench integer HSL predictor.
// Depends on rgbhsl_pkg and the converter RTL.
module tb;
  import rgbhsl_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int SatSplit   = 128;
  localparam int MaxReports = 10;
  localparam int RandItems  = 1300;

  typedef struct packed {
    logic [23:0] pixel;
    logic [8:0]  hue;
    logic [6:0]  sat;
    logic [6:0]  light;
  } hsl_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [23:0] pixel_rgb_i;
  logic        done_o;
  logic [8:0]  hue_deg_o;
  logic [6:0]  sat_pct_o;
  logic [6:0]  light_pct_o;

  hsl_t hsl_expected[$];
  int   n_fail   = 0;
  int   n_cycles = 0;
  bit   gaps_on  = 1'b1;

  rgb_to_hsl_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .pixel_rgb_i(pixel_rgb_i),
    .done_o     (done_o),
    .hue_deg_o  (hue_deg_o),
    .sat_pct_o  (sat_pct_o),
    .light_pct_o(light_pct_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic hsl_t hsl_of(logic [23:0] px);
    int      r, g, b, top, low, spread, sum, h, s;
    sector_e sec;
    hsl_t    res;
    r = int'(px[23:16]);
    g = int'(px[15:8]);
    b = int'(px[7:0]);
    sec = SecRed;
    top = r;
    // ties resolve towards blue, then green
    if (g >= r && g >= b) begin
      sec = SecGreen;
      top = g;
    end
    if (b >= r && b >= g) begin
      sec = SecBlue;
      top = b;
    end
    low = r;
    if (g < low) low = g;
    if (b < low) low = b;
    spread = top - low;
    sum    = top + low;
    h = 0;
    s = 0;
    if (spread != 0) begin
      case (sec)
        SecRed:   h = (60 * (g - b)) / spread;
        SecGreen: h = (60 * (b - r) + int'(GreenBase) * spread) / spread;
        default:  h = (60 * (r - g) + int'(BlueBase) * spread) / spread;
      endcase
      if (h < 0) h = h + int'(FullTurn);
      if (sum / 2 <= SatSplit) s = (100 * spread) / sum;
      else s = (100 * spread) / (int'(SpanSum) - sum);
    end
    res.pixel = px;
    res.hue   = 9'(h);
    res.sat   = 7'(s);
    res.light = 7'((100 * sum) / int'(SpanSum));
    return res;
  endfunction

  // called and returns at a falling edge; start_i stays high between back-to-back requests
  task automatic send_pixel(input logic [23:0] px);
    while (gaps_on && $urandom_range(99) < 26) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    pixel_rgb_i <= px;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    hsl_expected.push_back(hsl_of(px));
    @(negedge clk_i);
  endtask

  task automatic test_primaries();
    logic [23:0] px [7] = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                            24'h00FFFF, 24'hFF00FF, 24'h800000};
    foreach (px[i]) send_pixel(px[i]);
  endtask

  task automatic test_greys();
    logic [23:0] px [5] = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F, 24'h010101};
    foreach (px[i]) send_pixel(px[i]);
  endtask

  task automatic test_ties();
    logic [23:0] px [3] = '{24'h808040, 24'h408080, 24'h804080};
    foreach (px[i]) send_pixel(px[i]);
  endtask

  // slightly negative red hue truncates to zero; larger ones wrap by a full turn
  task automatic test_hue_wrap();
    logic [23:0] px [3] = '{24'hFF0001, 24'hFE0102, 24'hFF00FE};
    foreach (px[i]) send_pixel(px[i]);
  endtask

  task automatic test_sat_split();
    logic [23:0] px [3] = '{24'hC86439, 24'hC8643A, 24'hC76439};
    foreach (px[i]) send_pixel(px[i]);
  endtask

  task automatic test_random();
    logic [7:0]  corner_vals [8] = '{8'h00, 8'h01, 8'h02, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};
    logic [7:0]  ch [3];
    logic [7:0]  a, c;
    int          base, v;
    for (int n = 0; n < RandItems; n++) begin
      gaps_on = !(n >= 500 && n < 850);
      case ($urandom_range(3))
        0: begin
          {ch[0], ch[1], ch[2]} = 24'($urandom);
        end
        1: begin
          // near grey: tiny spreads stress hue rounding
          base = $urandom_range(255);
          for (int k = 0; k < 3; k++) begin
            v = base + $urandom_range(6) - 3;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            ch[k] = 8'(v);
          end
        end
        2: begin
          a = 8'($urandom);
          c = 8'($urandom);
          case ($urandom_range(2))
            0: {ch[0], ch[1], ch[2]} = {a, a, c};
            1: {ch[0], ch[1], ch[2]} = {a, c, a};
            default: {ch[0], ch[1], ch[2]} = {c, a, a};
          endcase
        end
        default: begin
          for (int k = 0; k < 3; k++) ch[k] = corner_vals[$urandom_range(7)];
        end
      endcase
      send_pixel({ch[0], ch[1], ch[2]});
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin : result_check
    hsl_t want;
    if (rst_ni && done_o) begin
      if (hsl_expected.size() == 0) begin
        n_fail++;
        if (n_fail <= MaxReports)
          $display("result with no request: hue %0d sat %0d light %0d",
                   hue_deg_o, sat_pct_o, light_pct_o);
      end else begin
        want = hsl_expected.pop_front();
        if (hue_deg_o !== want.hue || sat_pct_o !== want.sat || light_pct_o !== want.light)
        begin
          n_fail++;
          if (n_fail <= MaxReports)
            $display("pixel %06h: expected hsl %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.pixel, want.hue, want.sat, want.light,
                     hue_deg_o, sat_pct_o, light_pct_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    pixel_rgb_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_primaries();
    test_greys();
    test_ties();
    test_hue_wrap();
    test_sat_split();
    test_random();
    start_i <= 1'b0;
    while (hsl_expected.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
